@@ sv/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Request and status codes, default sizes and the control bundle that the
// top level hands to every cell of the chain.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Default sizes
  localparam int unsigned CAPACITY_DEF  = 16;
  localparam int unsigned PRIO_BITS_DEF = 16;
  localparam int unsigned TAG_BITS_DEF  = 32;

  // Request codes
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_e;

  // Status codes
  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_EMPTY_REMOVE = 2'd1,
    ST_FULL_INSERT  = 2'd2
  } status_e;

  // Per-cycle command broadcast to all cells
  typedef struct packed {
    logic ins;  // insert the new item into the sorted chain
    logic rem;  // drop the head, move everything up by one
  } cell_ctrl_t;

endpackage

@@ sv/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell: one slot of the shift-register priority queue
// Holds one (priority, tag) entry. On insert it keeps its entry, takes the
// new one, or takes its upper neighbor's; on remove it takes its lower
// neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned PRIO_BITS = PRIO_BITS_DEF,
  parameter int unsigned TAG_BITS  = TAG_BITS_DEF
) (
  input  logic                 clk_i,
  input  cell_ctrl_t           ctrl_i,
  input  logic [PRIO_BITS-1:0] new_prio_i,
  input  logic [TAG_BITS-1:0]  new_tag_i,
  input  logic                 occupied_i,
  // upper neighbor (toward the head)
  input  logic                 prev_go_i,
  input  logic [PRIO_BITS-1:0] prev_prio_i,
  input  logic [TAG_BITS-1:0]  prev_tag_i,
  // lower neighbor (toward the tail)
  input  logic [PRIO_BITS-1:0] next_prio_i,
  input  logic [TAG_BITS-1:0]  next_tag_i,
  // own entry and insert decision
  output logic                 go_o,
  output logic [PRIO_BITS-1:0] prio_o,
  output logic [TAG_BITS-1:0]  tag_o
);

  logic [PRIO_BITS-1:0] prio_q, prio_d;
  logic [TAG_BITS-1:0]  tag_q, tag_d;

  // Cell lies at or behind the insert point unless it holds an entry of
  // equal or higher priority
  assign go_o = !(occupied_i && (prio_q >= new_prio_i));

  // Select the next entry
  always_comb begin
    prio_d = prio_q;
    tag_d  = tag_q;
    if (ctrl_i.ins) begin
      if (prev_go_i) begin
        prio_d = prev_prio_i;
        tag_d  = prev_tag_i;
      end else if (go_o) begin
        prio_d = new_prio_i;
        tag_d  = new_tag_i;
      end
    end else if (ctrl_i.rem) begin
      prio_d = next_prio_i;
      tag_d  = next_tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    tag_q  <= tag_d;
  end

  assign prio_o = prio_q;
  assign tag_o  = tag_q;

endmodule

@@ sv/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue, highest priority first
// A chain of CAPACITY cells kept sorted; equal priorities keep arrival
// order. Each request inserts, removes the head or clears (req_type_i 3
// changes nothing), and returns one result describing the queue afterwards.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-----------------------------------
//   request  | start, busy              | req_type_i, entry_priority_i,
//            |                          | entry_tag_i
//   result   | result_valid_o (strobe)  | head_tag_o, head_priority_o,
//            |                          | entry_count_o, is_empty_o,
//            |                          | is_full_o, status_o
//
// One item per cycle: every cell updates in the cycle of the request, and
// the result strobes in the next cycle. busy stays low, so an item may be
// accepted every cycle. Reset empties the queue at once; cell contents are
// not cleared, only entries below the count are ever read. The receiver
// cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY  = CAPACITY_DEF,
  parameter int unsigned PRIO_BITS = PRIO_BITS_DEF,
  parameter int unsigned TAG_BITS  = TAG_BITS_DEF,
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           req_type_i,
  input  logic [PRIO_BITS-1:0] entry_priority_i,
  input  logic [TAG_BITS-1:0]  entry_tag_i,
  output logic                 result_valid_o,
  output logic [TAG_BITS-1:0]  head_tag_o,
  output logic [PRIO_BITS-1:0] head_priority_o,
  output logic [CNT_W-1:0]     entry_count_o,
  output logic                 is_empty_o,
  output logic                 is_full_o,
  output logic [1:0]           status_o
);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic                 accept;
  logic                 empty, full;
  cell_ctrl_t           ctrl;
  status_e              status_d, status_q;
  logic [CNT_W-1:0]     count_d, count_q;
  logic                 valid_q;

  logic [PRIO_BITS-1:0] prio_w [CAPACITY];
  logic [TAG_BITS-1:0]  tag_w  [CAPACITY];
  logic                 go_w   [CAPACITY];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign empty  = (count_q == '0);
  assign full   = (count_q == CAP_CNT);

  // Decode the request into cell commands, next count and status
  always_comb begin
    ctrl     = '0;
    count_d  = count_q;
    status_d = ST_OK;
    if (accept) begin
      case (req_e'(req_type_i))
        REQ_INSERT: begin
          if (full) begin
            status_d = ST_FULL_INSERT;
          end else begin
            ctrl.ins = 1'b1;
            count_d  = count_q + CNT_W'(1);
          end
        end
        REQ_REMOVE: begin
          if (empty) begin
            status_d = ST_EMPTY_REMOVE;
          end else begin
            ctrl.rem = 1'b1;
            count_d  = count_q - CNT_W'(1);
          end
        end
        REQ_CLEAR: begin
          count_d = '0;
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  // Chain of cells, head at index 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                 prev_go;
    logic [PRIO_BITS-1:0] prev_prio, next_prio;
    logic [TAG_BITS-1:0]  prev_tag, next_tag;

    if (i == 0) begin : g_head
      assign prev_go   = 1'b0;
      assign prev_prio = '0;
      assign prev_tag  = '0;
    end else begin : g_body
      assign prev_go   = go_w[i-1];
      assign prev_prio = prio_w[i-1];
      assign prev_tag  = tag_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_prio = '0;
      assign next_tag  = '0;
    end else begin : g_inner
      assign next_prio = prio_w[i+1];
      assign next_tag  = tag_w[i+1];
    end

    spq_cell #(
      .PRIO_BITS (PRIO_BITS),
      .TAG_BITS  (TAG_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .new_prio_i  (entry_priority_i),
      .new_tag_i   (entry_tag_i),
      .occupied_i  (count_q > CNT_W'(i)),
      .prev_go_i   (prev_go),
      .prev_prio_i (prev_prio),
      .prev_tag_i  (prev_tag),
      .next_prio_i (next_prio),
      .next_tag_i  (next_tag),
      .go_o        (go_w[i]),
      .prio_o      (prio_w[i]),
      .tag_o       (tag_w[i])
    );
  end

  // Hold count, status and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      status_q <= ST_OK;
      valid_q  <= 1'b0;
    end else begin
      count_q  <= count_d;
      valid_q  <= accept;
      if (accept) begin
        status_q <= status_d;
      end
    end
  end

  // Result fields follow the updated state
  assign result_valid_o  = valid_q;
  assign head_tag_o      = empty ? '0 : tag_w[0];
  assign head_priority_o = empty ? '0 : prio_w[0];
  assign entry_count_o   = count_q;
  assign is_empty_o      = empty;
  assign is_full_o       = full;
  assign status_o        = status_q;

endmodule
